// ===== hw/rtl/text_console_writer_macros.svh =====
// Assertion helpers used by the checker tcw_chk.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

    // Fixed field widths of the request and result items, and of a RAM cell.
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 16;

    // Command codes.
    localparam logic [1:0] CMD_PRINT = 2'd0;
    localparam logic [1:0] CMD_BACK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Special characters.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ERASE   = 8'h08;
    localparam logic [7:0] CH_ERRMARK = 8'h45;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Configuration register indexes.
    localparam logic CFG_DEFAULT_ATTR = 1'b0;
    localparam logic CFG_ERROR_ATTR   = 1'b1;

    // One result item.
    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              position_error;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_attr;
    } t_res;

endpackage

// ===== hw/rtl/text_console_writer.sv =====
// Character-cell text console, ROWS x COLS cells of {attribute, character} held in one
// single-port-write, one-read synchronous RAM, plus a cursor kept as row and column.
// A request is taken only while the controller is idle. For an ordinary print, erase,
// backspace or read, the accept cycle issues the read and the next cycle modifies and
// writes back; the controller waits in ST_RESP while the result register stays full.
// Clear walks the whole RAM, one cell a cycle. A print or newline that passes the bottom
// row scrolls: the copy walk reads cell i+COLS and writes cell i in the next cycle, then
// zeroes the bottom row. After reset the RAM is swept to zero, during which o_s_tready
// stays low; configuration writes are taken at any time. Since only one request is in
// flight and RAM writes land before the next read is issued, reads never need forwarding.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // row[4:0], col[11:5], character[19:12], attr[27:20]
    input  logic [2:0]  i_s_tuser,   // cmd[1:0], use_position[2]
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                     // cell_char[19:12], cell_attr[27:20]
    output logic        o_m_tuser,   // position_error[0]
    // Configuration writes.
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLS);

    localparam logic [AW-1:0]    COLS_A   = AW'(COLS);
    localparam logic [AW-1:0]    LAST_A   = AW'(CELLS - 1);
    localparam logic [CW-1:0]    CNT_END  = CW'(CELLS);
    localparam logic [CW-1:0]    CNT_LAST = CW'(CELLS - 1);
    localparam logic [CW-1:0]    CNT_COPY = CW'(CELLS - COLS);
    localparam logic [CW-1:0]    CNT_COLS = CW'(COLS);
    localparam logic [ROW_W:0]   ROW_LIM  = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0]   COL_LIM  = (COL_W + 1)'(COLS);
    localparam logic [RW-1:0]    ROW_MAX  = RW'(ROWS - 1);
    localparam logic [CLW-1:0]   COL_MAX  = CLW'(COLS - 1);

    // Controller states.
    localparam logic [2:0] ST_INIT   = 3'd0;  // reset sweep, zero every cell
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;  // modify and write back
    localparam logic [2:0] ST_FILL   = 3'd3;  // clear sweep
    localparam logic [2:0] ST_SCROLL = 3'd4;  // copy up one row, blank bottom row
    localparam logic [2:0] ST_RESP   = 3'd5;  // wait for the result register

    // Control state.
    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [RW-1:0]  r_cur_row, n_cur_row;
    logic [CLW-1:0] r_cur_col, n_cur_col;
    logic [7:0]     r_def_attr, r_err_attr;

    // Request held for the execute cycle.
    logic [1:0]     r_cmd;
    logic           r_bad;
    logic [RW-1:0]  r_trow;
    logic [CLW-1:0] r_tcol;
    logic [AW-1:0]  r_taddr;
    logic [7:0]     r_char, r_attr;
    logic [15:0]    r_fill, n_fill;
    t_res           r_res, n_res;

    // Request fields.
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    logic [7:0]       in_char, in_attr;
    logic [1:0]       in_cmd;
    logic             in_usepos;

    assign in_row    = i_s_tdata[4:0];
    assign in_col    = i_s_tdata[11:5];
    assign in_char   = i_s_tdata[19:12];
    assign in_attr   = i_s_tdata[27:20];
    assign in_cmd    = i_s_tuser[1:0];
    assign in_usepos = i_s_tuser[2];

    logic           s_accept;
    logic           use_given, off_screen;
    logic [RW-1:0]  sel_row;
    logic [CLW-1:0] sel_col;
    logic [AW-1:0]  sel_addr;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Only print and read honor an explicit position; backspace works at the cursor.
    assign use_given  = in_usepos && (in_cmd == CMD_PRINT || in_cmd == CMD_READ);
    assign off_screen = ({1'b0, in_row} >= ROW_LIM) || ({1'b0, in_col} >= COL_LIM);
    assign sel_row    = use_given ? RW'(in_row) : r_cur_row;
    assign sel_col    = use_given ? CLW'(in_col) : r_cur_col;
    assign sel_addr   = AW'(sel_row) * COLS_A + AW'(sel_col);

    // RAM ports.
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    assign ram_re    = s_accept || (r_state == ST_SCROLL && r_cnt < CNT_COPY);
    assign ram_raddr = (r_state == ST_SCROLL) ? AW'(r_cnt + CNT_COLS) : sel_addr;

    tcw_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result register.
    logic out_free, out_load;
    t_res out_res;

    tcw_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (out_load),
        .i_res      (out_res),
        .o_free     (out_free),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Execute-cycle helpers.
    logic [7:0] attr_eff;
    logic       last_row, last_col;

    assign attr_eff = (r_attr == 8'd0) ? r_def_attr : r_attr;
    assign last_row = (r_trow == ROW_MAX);
    assign last_col = (r_tcol == COL_MAX);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_fill    = r_fill;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = 16'd0;
        out_load  = 1'b0;
        out_res   = r_res;

        case (r_state)
            ST_INIT: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res.position_error = 1'b0;
                n_res.cell_char      = 8'd0;
                n_res.cell_attr      = 8'd0;
                n_state              = ST_RESP;
                case (r_cmd)
                    CMD_PRINT: begin
                        if (r_bad) begin
                            // Drop the character, mark the last cell.
                            ram_we               = 1'b1;
                            ram_waddr            = LAST_A;
                            ram_wdata            = {r_err_attr, CH_ERRMARK};
                            n_res.position_error = 1'b1;
                        end else if (r_char == CH_NEWLINE) begin
                            n_cur_col = '0;
                            if (last_row) begin
                                n_cur_row = ROW_MAX;
                                n_state   = ST_SCROLL;
                            end else begin
                                n_cur_row = r_trow + 1'b1;
                            end
                        end else if (r_char == CH_ERASE) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_taddr;
                            ram_wdata = {attr_eff, 8'd0};
                            n_cur_row = r_trow;
                            n_cur_col = r_tcol;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_taddr;
                            ram_wdata = {attr_eff, r_char};
                            if (!last_col) begin
                                n_cur_row = r_trow;
                                n_cur_col = r_tcol + 1'b1;
                            end else if (!last_row) begin
                                n_cur_row = r_trow + 1'b1;
                                n_cur_col = '0;
                            end else begin
                                n_cur_row = ROW_MAX;
                                n_cur_col = '0;
                                n_state   = ST_SCROLL;
                            end
                        end
                    end
                    CMD_BACK: begin
                        // Step back one cell, stay put at the home cell.
                        ram_we    = 1'b1;
                        ram_waddr = (r_taddr == '0) ? r_taddr : r_taddr - 1'b1;
                        ram_wdata = {r_def_attr, 8'd0};
                        if (r_cur_col != '0) begin
                            n_cur_col = r_cur_col - 1'b1;
                        end else if (r_cur_row != '0) begin
                            n_cur_row = r_cur_row - 1'b1;
                            n_cur_col = COL_MAX;
                        end
                    end
                    CMD_CLEAR: begin
                        n_cur_row = '0;
                        n_cur_col = '0;
                        n_fill    = {r_def_attr, CH_SPACE};
                        n_state   = ST_FILL;
                    end
                    default: begin
                        if (r_bad) begin
                            n_res.position_error = 1'b1;
                        end else begin
                            n_res.cell_char = ram_rdata[7:0];
                            n_res.cell_attr = ram_rdata[15:8];
                        end
                    end
                endcase
                n_res.cursor_row = ROW_W'(n_cur_row);
                n_res.cursor_col = COL_W'(n_cur_col);
                n_cnt            = '0;
                // Hand the result straight on when no sweep follows and the result register is free.
                if (n_state == ST_RESP && out_free) begin
                    out_load = 1'b1;
                    out_res  = n_res;
                    n_state  = ST_IDLE;
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = r_fill;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_RESP;
                end
            end
            ST_SCROLL: begin
                // Write back the word read last cycle one row up; zero the bottom row.
                ram_we    = (r_cnt != '0);
                ram_waddr = AW'(r_cnt - 1'b1);
                ram_wdata = (r_cnt <= CNT_COPY) ? ram_rdata : 16'd0;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_END) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_attr <= 8'd15;
            r_err_attr <= 8'd244;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_DEFAULT_ATTR: r_def_attr <= i_cfg_wdata;
                CFG_ERROR_ATTR:   r_err_attr <= i_cfg_wdata;
                default:          r_def_attr <= r_def_attr;
            endcase
        end
    end

    // Request capture and pending result.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd   <= in_cmd;
            r_bad   <= use_given && off_screen;
            r_trow  <= sel_row;
            r_tcol  <= sel_col;
            r_taddr <= sel_addr;
            r_char  <= in_char;
            r_attr  <= in_attr;
        end
        r_fill <= n_fill;
        r_res  <= n_res;
    end

endmodule

// ===== hw/rtl/tcw_ram.sv =====
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read word while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcw_out.sv =====
module tcw_out
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_res        i_res,
    output logic        o_free,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [31:0] o_m_tdata,
    output logic        o_m_tuser
);

    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {4'd0, r_res.cell_attr, r_res.cell_char,
                         r_res.cursor_col, r_res.cursor_row};
    assign o_m_tuser  = r_res.position_error;

endmodule

// ===== hw/rtl/tcw_chk.sv =====
`include "text_console_writer_macros.svh"

module tcw_chk #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    // A stalled result stays offered.
    `TCW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid,
        "result dropped while stalled")

    // One request in flight: a taken request closes the input for the next cycle.
    `TCW_ASSERT_NEXT(a_one_inflight, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready,
        "request taken while another is in flight")

    // An off-screen position never comes with cell data.
    `TCW_ASSERT_SAME(a_err_no_cell, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
        o_m_tdata[27:12] == 16'd0, "cell data with position error")

    // The reported cursor stays on screen.
    `TCW_ASSERT_SAME(a_cursor_on_screen, i_clk, i_rst_n, o_m_tvalid,
        (32'(o_m_tdata[4:0]) < ROWS) && (32'(o_m_tdata[11:5]) < COLS),
        "cursor off screen")

endmodule

bind text_console_writer tcw_chk #(.COLS(COLS), .ROWS(ROWS)) u_tcw_chk (.*);
